### sv/rwcs_pkg.sv
// shared constants, codes and transaction types of the raycast wall column shader
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package rwcs_pkg;

   // texture geometry
   localparam int TEX_BITS  = 6;
   localparam int TEX_SIZE  = 1 << TEX_BITS;
   localparam int NUM_SIDES = 4;
   localparam int SIDE_BITS = 2;
   localparam int ADDR_W    = SIDE_BITS + 2 * TEX_BITS;
   localparam int TEX_WORDS = NUM_SIDES * TEX_SIZE * TEX_SIZE;

   // screen and fixed point formats
   localparam int SCREEN_ROWS = 1024;
   localparam int ROW_BITS    = 10;
   localparam int FRAC_BITS   = 8;
   localparam int COORD_W     = 24;
   localparam int EDGE_W      = 20;
   localparam int COLOR_W     = 32;
   localparam int TILE_BITS   = 6 + FRAC_BITS;   // one map tile is 64 units

   // texture row division: n * TEX_SIZE / d
   localparam int NPOS_W = ((ROW_BITS + FRAC_BITS > EDGE_W - 1) ?
                            (ROW_BITS + FRAC_BITS) : (EDGE_W - 1)) + 1;
   localparam int NUM_W  = NPOS_W + TEX_BITS;
   localparam int DEN_W  = EDGE_W;

   // request kinds
   localparam logic REQ_TEXEL = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // region codes
   localparam logic [1:0] REGION_CEILING = 2'd0;
   localparam logic [1:0] REGION_WALL    = 2'd1;
   localparam logic [1:0] REGION_FLOOR   = 2'd2;

   // side codes
   localparam logic [SIDE_BITS-1:0] SIDE_NORTH = 2'd0;
   localparam logic [SIDE_BITS-1:0] SIDE_SOUTH = 2'd1;
   localparam logic [SIDE_BITS-1:0] SIDE_EAST  = 2'd2;
   localparam logic [SIDE_BITS-1:0] SIDE_WEST  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 1'd1;

   localparam logic [COLOR_W-1:0] CEILING_RESET = 32'h00FF0000;
   localparam logic [COLOR_W-1:0] FLOOR_RESET   = 32'h00FFFF00;

   // one input transaction
   typedef struct packed {
      logic                        req_type;
      logic [SIDE_BITS-1:0]        texture_side;
      logic [TEX_BITS-1:0]         texel_row;
      logic [TEX_BITS-1:0]         texel_col;
      logic [COLOR_W-1:0]          texel_color;
      logic signed [COORD_W-1:0]   hit_x;
      logic signed [COORD_W-1:0]   hit_y;
      logic signed [COORD_W-1:0]   viewer_x;
      logic signed [COORD_W-1:0]   viewer_y;
      logic signed [EDGE_W-1:0]    wall_top;
      logic signed [EDGE_W-1:0]    wall_bottom;
      logic [ROW_BITS-1:0]         screen_row;
   } req_item_type;

   // what travels beside the divider
   typedef struct packed {
      logic                 is_pix;
      logic [SIDE_BITS-1:0] side;
      logic [1:0]           region;
      logic [TEX_BITS-1:0]  row;     // texel row of a write
      logic [TEX_BITS-1:0]  col;     // texel column of a write, tex_x of a pixel
      logic [COLOR_W-1:0]   color;
   } tag_type;

endpackage

`default_nettype wire

### sv/rwcs_if.sv
// valid/ready channel interfaces: request, response and register write
// depends on rwcs_pkg for field widths
`default_nettype none

interface rwcs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [rwcs_pkg::SIDE_BITS-1:0]        texture_side;
   logic [rwcs_pkg::TEX_BITS-1:0]         texel_row;
   logic [rwcs_pkg::TEX_BITS-1:0]         texel_col;
   logic [rwcs_pkg::COLOR_W-1:0]          texel_color;
   logic signed [rwcs_pkg::COORD_W-1:0]   hit_x;
   logic signed [rwcs_pkg::COORD_W-1:0]   hit_y;
   logic signed [rwcs_pkg::COORD_W-1:0]   viewer_x;
   logic signed [rwcs_pkg::COORD_W-1:0]   viewer_y;
   logic signed [rwcs_pkg::EDGE_W-1:0]    wall_top;
   logic signed [rwcs_pkg::EDGE_W-1:0]    wall_bottom;
   logic [rwcs_pkg::ROW_BITS-1:0]         screen_row;

   modport source (output valid, req_type, texture_side, texel_row, texel_col, texel_color,
                   hit_x, hit_y, viewer_x, viewer_y, wall_top, wall_bottom, screen_row,
                   input ready);
   modport sink (input valid, req_type, texture_side, texel_row, texel_col, texel_color,
                 hit_x, hit_y, viewer_x, viewer_y, wall_top, wall_bottom, screen_row,
                 output ready);
endinterface

interface rwcs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rwcs_pkg::COLOR_W-1:0]    pixel_color;
   logic [1:0]                      region;
   logic [rwcs_pkg::SIDE_BITS-1:0]  wall_side;

   modport source (output valid, pixel_color, region, wall_side, input ready);
   modport sink (input valid, pixel_color, region, wall_side, output ready);
endinterface

interface rwcs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rwcs_pkg::CSR_IDX_W-1:0]    index;
   logic [rwcs_pkg::COLOR_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/rwcs_decode.sv
// first pipeline stage: side choice, region, tex_x and the division operands
// depends on rwcs_pkg
`default_nettype none

module rwcs_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire rwcs_pkg::req_item_type        in_item,
   output logic                               out_valid,
   output logic [rwcs_pkg::NUM_W-1:0]         out_num,
   output logic [rwcs_pkg::DEN_W-1:0]         out_den,
   output rwcs_pkg::tag_type                  out_tag
);

   localparam int DW = rwcs_pkg::COORD_W + 1;
   localparam int EW = rwcs_pkg::EDGE_W + 1;
   localparam int NW = rwcs_pkg::NPOS_W + 2;

   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0]        adx, ady;
   logic                 x_major;
   logic signed [rwcs_pkg::COORD_W-1:0] c_sel;
   logic [rwcs_pkg::COORD_W-1:0]        c_abs;
   logic signed [EW-1:0] top_x, bot_x, top_neg, bot_neg, top_tr, bot_tr, row_x, d_full;
   logic signed [NW-1:0] n_full;
   logic [rwcs_pkg::SIDE_BITS-1:0] side;
   logic [1:0]           region;
   logic                 on_screen;

   logic                        valid_ff, valid_in;
   logic [rwcs_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [rwcs_pkg::DEN_W-1:0]  den_ff, den_in;
   rwcs_pkg::tag_type           tag_ff, tag_in;

   always_comb begin
      dx = DW'(in_item.hit_x) - DW'(in_item.viewer_x);
      dy = DW'(in_item.hit_y) - DW'(in_item.viewer_y);
      adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
      ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
      x_major = adx > ady;

      if (x_major) begin
         side = (in_item.hit_x > in_item.viewer_x) ? rwcs_pkg::SIDE_EAST : rwcs_pkg::SIDE_WEST;
      end else begin
         side = (in_item.hit_y > in_item.viewer_y) ? rwcs_pkg::SIDE_SOUTH
                                                   : rwcs_pkg::SIDE_NORTH;
      end

      // tex_x is the fraction across the tile
      c_sel = x_major ? in_item.hit_y : in_item.hit_x;
      c_abs = c_sel[rwcs_pkg::COORD_W-1] ? rwcs_pkg::COORD_W'(-c_sel)
                                         : rwcs_pkg::COORD_W'(c_sel);

      // rows truncate toward zero
      top_x   = EW'(in_item.wall_top);
      bot_x   = EW'(in_item.wall_bottom);
      top_neg = -top_x;
      bot_neg = -bot_x;
      top_tr  = top_x[EW-1] ? -(top_neg >>> rwcs_pkg::FRAC_BITS) : (top_x >>> rwcs_pkg::FRAC_BITS);
      bot_tr  = bot_x[EW-1] ? -(bot_neg >>> rwcs_pkg::FRAC_BITS) : (bot_x >>> rwcs_pkg::FRAC_BITS);
      row_x   = EW'({1'b0, in_item.screen_row});

      priority if (row_x < top_tr) begin
         region = rwcs_pkg::REGION_CEILING;
      end else if (row_x < bot_tr) begin
         region = rwcs_pkg::REGION_WALL;
      end else begin
         region = rwcs_pkg::REGION_FLOOR;
      end

      n_full = NW'({1'b0, in_item.screen_row, rwcs_pkg::FRAC_BITS'(0)}) - NW'(in_item.wall_top);
      d_full = bot_x - top_x;
      on_screen = 32'(in_item.screen_row) < 32'(rwcs_pkg::SCREEN_ROWS);

      // a negative row offset samples texture row 0
      num_in = (n_full > 0) ? {n_full[rwcs_pkg::NPOS_W-1:0], rwcs_pkg::TEX_BITS'(0)}
                            : '0;
      den_in = d_full[rwcs_pkg::DEN_W-1:0];

      tag_in.is_pix = (in_item.req_type == rwcs_pkg::REQ_PIXEL);
      tag_in.color  = in_item.texel_color;
      tag_in.region = region;
      tag_in.row    = in_item.texel_row;
      if (in_item.req_type == rwcs_pkg::REQ_PIXEL) begin
         tag_in.side = side;
         tag_in.col  = c_abs[rwcs_pkg::TILE_BITS-1 -: rwcs_pkg::TEX_BITS];
      end else begin
         tag_in.side = in_item.texture_side;
         tag_in.col  = in_item.texel_col;
      end

      valid_in = in_valid && ((in_item.req_type == rwcs_pkg::REQ_TEXEL) || on_screen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         den_ff <= den_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

### sv/rwcs_divider.sv
// pipelined restoring divider, one quotient bit per stage, keeps the low
// TEX_BITS quotient bits (texture row mod TEX_SIZE); depends on rwcs_pkg
`default_nettype none

module rwcs_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [rwcs_pkg::NUM_W-1:0]    in_num,
   input  wire logic [rwcs_pkg::DEN_W-1:0]    in_den,
   input  wire rwcs_pkg::tag_type             in_tag,
   output logic                               out_valid,
   output logic [rwcs_pkg::TEX_BITS-1:0]      out_quot,
   output rwcs_pkg::tag_type                  out_tag
);

   localparam int NS = rwcs_pkg::NUM_W;

   // stage inputs
   logic                          pv   [NS];
   logic [rwcs_pkg::DEN_W-1:0]    prem [NS];
   logic [rwcs_pkg::NUM_W-1:0]    pnum [NS];
   logic [rwcs_pkg::DEN_W-1:0]    pden [NS];
   logic [rwcs_pkg::TEX_BITS-1:0] pq   [NS];
   rwcs_pkg::tag_type             ptag [NS];
   logic [rwcs_pkg::DEN_W:0]      trial [NS];

   logic                          valid_ff [NS];
   logic [rwcs_pkg::DEN_W-1:0]    rem_ff   [NS];
   logic [rwcs_pkg::DEN_W-1:0]    rem_in   [NS];
   logic [rwcs_pkg::NUM_W-1:0]    num_ff   [NS];
   logic [rwcs_pkg::DEN_W-1:0]    den_ff   [NS];
   logic [rwcs_pkg::TEX_BITS-1:0] q_ff     [NS];
   logic [rwcs_pkg::TEX_BITS-1:0] q_in     [NS];
   rwcs_pkg::tag_type             tag_ff   [NS];

   always_comb begin
      pv[0]   = in_valid;
      prem[0] = '0;
      pnum[0] = in_num;
      pden[0] = in_den;
      pq[0]   = '0;
      ptag[0] = in_tag;
      for (int k = 1; k < NS; k++) begin
         pv[k]   = valid_ff[k-1];
         prem[k] = rem_ff[k-1];
         pnum[k] = num_ff[k-1];
         pden[k] = den_ff[k-1];
         pq[k]   = q_ff[k-1];
         ptag[k] = tag_ff[k-1];
      end
      for (int k = 0; k < NS; k++) begin
         trial[k] = {prem[k], pnum[k][rwcs_pkg::NUM_W-1]};
         if (trial[k] >= {1'b0, pden[k]}) begin
            rem_in[k] = rwcs_pkg::DEN_W'(trial[k] - {1'b0, pden[k]});
            q_in[k]   = {pq[k][rwcs_pkg::TEX_BITS-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][rwcs_pkg::DEN_W-1:0];
            q_in[k]   = {pq[k][rwcs_pkg::TEX_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= pv[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= {pnum[k][rwcs_pkg::NUM_W-2:0], 1'b0};
            den_ff[k] <= pden[k];
            q_ff[k]   <= q_in[k];
            tag_ff[k] <= ptag[k];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quot  = q_ff[NS-1];
   assign out_tag   = tag_ff[NS-1];

endmodule

`default_nettype wire

### sv/rwcs_tex_mem.sv
// texture store: one synchronous port, texel writes and pixel reads in
// pipeline order, read data registered; depends on rwcs_pkg
`default_nettype none

module rwcs_tex_mem (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire logic [rwcs_pkg::TEX_BITS-1:0]  in_quot,
   input  wire rwcs_pkg::tag_type              in_tag,
   output logic                                out_valid,
   output logic [rwcs_pkg::COLOR_W-1:0]        out_texel,
   output logic [1:0]                          out_region,
   output logic [rwcs_pkg::SIDE_BITS-1:0]      out_side
);

   logic [rwcs_pkg::COLOR_W-1:0] mem [rwcs_pkg::TEX_WORDS];

   logic [rwcs_pkg::ADDR_W-1:0]    addr;
   logic                           wr_en;
   logic                           valid_ff, valid_in;
   logic [rwcs_pkg::COLOR_W-1:0]   rd_ff;
   logic [1:0]                     region_ff;
   logic [rwcs_pkg::SIDE_BITS-1:0] side_ff;

   // a pixel uses tex_y from the divider as its row
   assign addr     = {in_tag.side, (in_tag.is_pix ? in_quot : in_tag.row), in_tag.col};
   assign wr_en    = adv && in_valid && !in_tag.is_pix;
   assign valid_in = in_valid && in_tag.is_pix;

   // both sides see one access per cycle in order, and none while the pipeline stalls, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= in_tag.color;
      end
      if (adv) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         region_ff <= in_tag.region;
         side_ff   <= in_tag.side;
      end
   end

   assign out_valid  = valid_ff;
   assign out_texel  = rd_ff;
   assign out_region = region_ff;
   assign out_side   = side_ff;

endmodule

`default_nettype wire

### sv/raycast_wall_column_shader.sv
// Raycast wall column shader, top level.
// req_ch takes two kinds of transaction: a texel write (req_type 0) that
// stores texel_color in one of four 64x64 textures, and a pixel request
// (req_type 1) that returns one rsp_ch transaction with the pixel colour,
// its region (ceiling, wall, floor) and the wall side hit. Texel writes and
// off-screen rows give no response. csr_ch writes the ceiling colour
// (index 0) and floor colour (index 1); it is always ready.
// Path from an accepted request to its response: one decode
// stage, 26 divider stages (one quotient bit each) and the texture read.
// Throughput: one transaction per cycle while the pipeline advances, set
// by the single texture port that serves one write or one read each cycle.
// The pipeline advances whenever the response register is empty or taken;
// when the receiver stalls, the whole pipeline and req_ch.ready hold.
// Reset clears the pipeline valid bits and restores the reset colours;
// texture contents are undefined until written and no clearing pass runs.
// depends on rwcs_pkg, rwcs_if, rwcs_decode, rwcs_divider, rwcs_tex_mem
`default_nettype none

module raycast_wall_column_shader (
   input  wire logic   clock,
   input  wire logic   reset,
   rwcs_req_if.sink    req_ch,
   rwcs_rsp_if.source  rsp_ch,
   rwcs_csr_if.sink    csr_ch
);

   logic                              adv;
   rwcs_pkg::req_item_type            req_item;

   logic                              dec_valid;
   logic [rwcs_pkg::NUM_W-1:0]        dec_num;
   logic [rwcs_pkg::DEN_W-1:0]        dec_den;
   rwcs_pkg::tag_type                 dec_tag;

   logic                              div_valid;
   logic [rwcs_pkg::TEX_BITS-1:0]     div_quot;
   rwcs_pkg::tag_type                 div_tag;

   logic                              mem_valid;
   logic [rwcs_pkg::COLOR_W-1:0]      mem_texel;
   logic [1:0]                        mem_region;
   logic [rwcs_pkg::SIDE_BITS-1:0]    mem_side;

   logic [rwcs_pkg::COLOR_W-1:0]      ceiling_ff;
   logic [rwcs_pkg::COLOR_W-1:0]      floor_ff;

   assign adv = !mem_valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      req_item.req_type     = req_ch.req_type;
      req_item.texture_side = req_ch.texture_side;
      req_item.texel_row    = req_ch.texel_row;
      req_item.texel_col    = req_ch.texel_col;
      req_item.texel_color  = req_ch.texel_color;
      req_item.hit_x        = req_ch.hit_x;
      req_item.hit_y        = req_ch.hit_y;
      req_item.viewer_x     = req_ch.viewer_x;
      req_item.viewer_y     = req_ch.viewer_y;
      req_item.wall_top     = req_ch.wall_top;
      req_item.wall_bottom  = req_ch.wall_bottom;
      req_item.screen_row   = req_ch.screen_row;
   end

   rwcs_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_item   (req_item),
      .out_valid (dec_valid),
      .out_num   (dec_num),
      .out_den   (dec_den),
      .out_tag   (dec_tag)
   );

   rwcs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dec_valid),
      .in_num    (dec_num),
      .in_den    (dec_den),
      .in_tag    (dec_tag),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   rwcs_tex_mem u_tex_mem (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (div_valid),
      .in_quot    (div_quot),
      .in_tag     (div_tag),
      .out_valid  (mem_valid),
      .out_texel  (mem_texel),
      .out_region (mem_region),
      .out_side   (mem_side)
   );

   // colour registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= rwcs_pkg::CEILING_RESET;
         floor_ff   <= rwcs_pkg::FLOOR_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            rwcs_pkg::CSR_CEILING: ceiling_ff <= csr_ch.data;
            rwcs_pkg::CSR_FLOOR:   floor_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid     = mem_valid;
   assign rsp_ch.region    = mem_region;
   assign rsp_ch.wall_side = mem_side;

   always_comb begin
      unique case (mem_region)
         rwcs_pkg::REGION_CEILING: rsp_ch.pixel_color = ceiling_ff;
         rwcs_pkg::REGION_WALL:    rsp_ch.pixel_color = mem_texel;
         default:                  rsp_ch.pixel_color = floor_ff;
      endcase
   end

`ifndef SYNTH
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(div_valid))
      else $error("divider output moved during a stall");

   a_pix_resp: assert property (@(posedge clock) disable iff (reset)
      adv && div_valid && div_tag.is_pix |=> rsp_ch.valid)
      else $error("pixel transaction lost at texture read");

   a_texel_quiet: assert property (@(posedge clock) disable iff (reset)
      adv && !(div_valid && div_tag.is_pix) |=> !rsp_ch.valid)
      else $error("response without a pixel transaction");

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.region == rwcs_pkg::REGION_CEILING ||
                        rsp_ch.region == rwcs_pkg::REGION_WALL ||
                        rsp_ch.region == rwcs_pkg::REGION_FLOOR))
      else $error("bad region on response");
`endif

endmodule

`default_nettype wire
